// File: sv/tfr_pkg.sv
// Shared types, format codes and expansion tables for the texel format expander.
`default_nettype none

package tfr_pkg;

  // Texel format codes held in the format register
  typedef enum logic [3:0] {
    FMT_RGBA32 = 4'd0,
    FMT_RGBA16 = 4'd1,
    FMT_IA16   = 4'd2,
    FMT_IA8    = 4'd3,
    FMT_IA4    = 4'd4,
    FMT_I8     = 4'd5,
    FMT_I4     = 4'd6,
    FMT_PAL4   = 4'd7,
    FMT_PAL8   = 4'd8
  } tfr_fmt_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_FORMAT     = 3'd0;
  localparam logic [2:0] CFG_LOAD_RAW   = 3'd1;
  localparam logic [2:0] CFG_TINT_RED   = 3'd2;
  localparam logic [2:0] CFG_TINT_GREEN = 3'd3;
  localparam logic [2:0] CFG_TINT_BLUE  = 3'd4;
  localparam logic [2:0] CFG_TINT_ALPHA = 3'd5;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned TINT_W      = 9;
  localparam logic [TINT_W-1:0] TINT_ONE = 9'd256;

  // x * 255 / 31, truncated
  localparam logic [7:0] EXP5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // x * 255 / 7, truncated
  localparam logic [7:0] EXP3 [8] = '{
    8'd0, 8'd36, 8'd72, 8'd109, 8'd145, 8'd182, 8'd218, 8'd255
  };

  // One expanded pixel before tinting
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       run_end;
    logic       unsupported;
  } tfr_pixel_t;

  // Nibble formats give two pixels per word
  function automatic logic tfr_two_pixels(input logic [3:0] fmt, input logic raw);
    tfr_two_pixels = !raw && (fmt == FMT_IA4 || fmt == FMT_I4);
  endfunction

endpackage

`default_nettype wire

// File: sv/tfr_expand.sv
// Decodes one pixel of a source word in the configured texel format.
`default_nettype none

module tfr_expand (
  input  wire logic [3:0]          fmt,
  input  wire logic                raw,
  input  wire logic [31:0]         word,
  input  wire logic                half,
  output tfr_pkg::tfr_pixel_t      pix
);
  import tfr_pkg::*;

  logic [7:0] b1;
  logic [7:0] b2;
  logic [3:0] nib;
  logic       pal;
  logic       two;

  assign b1  = word[15:8];
  assign b2  = word[7:0];
  assign nib = half ? b2[3:0] : b2[7:4];
  assign pal = (fmt == FMT_PAL4) || (fmt == FMT_PAL8);
  assign two = tfr_two_pixels(fmt, raw);

  always_comb begin
    pix             = '0;
    pix.run_end     = !two || half;
    pix.unsupported = 1'b0;
    priority if (pal) begin
      pix.unsupported = 1'b1;
    end else if (raw) begin
      pix.red   = word[31:24];
      pix.green = word[23:16];
      pix.blue  = word[15:8];
      pix.alpha = word[7:0];
    end else begin
      case (fmt)
        FMT_RGBA32: begin
          pix.red   = word[31:24];
          pix.green = word[23:16];
          pix.blue  = word[15:8];
          pix.alpha = word[7:0];
        end
        FMT_RGBA16: begin
          pix.red   = EXP5[b1[7:3]];
          pix.green = EXP5[{b1[2:0], b2[7:6]}];
          pix.blue  = EXP5[b2[5:1]];
          pix.alpha = {8{b2[0]}};
        end
        FMT_IA16: begin
          pix.red   = b1;
          pix.green = b1;
          pix.blue  = b1;
          pix.alpha = b2;
        end
        FMT_IA8: begin
          pix.red   = {b2[7:4], b2[7:4]};
          pix.green = {b2[7:4], b2[7:4]};
          pix.blue  = {b2[7:4], b2[7:4]};
          pix.alpha = {b2[3:0], b2[3:0]};
        end
        FMT_IA4: begin
          pix.red   = EXP3[nib[3:1]];
          pix.green = EXP3[nib[3:1]];
          pix.blue  = EXP3[nib[3:1]];
          pix.alpha = {8{nib[0]}};
        end
        FMT_I8: begin
          pix.red   = b2;
          pix.green = b2;
          pix.blue  = b2;
          pix.alpha = 8'hFF;
        end
        FMT_I4: begin
          pix.red   = {nib, nib};
          pix.green = {nib, nib};
          pix.blue  = {nib, nib};
          pix.alpha = 8'hFF;
        end
        default: begin
          // unlisted code
          pix.unsupported = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/texel_format_to_rgba8.sv
// Top level: texel format expander to tinted RGBA8 pixels.
`default_nettype none

// Takes one source word per handshake and emits RGBA8 pixel words, one per
// cycle while out_ready is high. RGBA32, RGBA5551, IA16, IA8 and I8 give one
// pixel per word; IA4 and I4 give two (high nibble first) and hold the input
// until both go. Narrow units sit in the low bits of source_word, first byte
// uppermost. load_raw makes every non-palette format pass as RGBA32. Palette
// formats, and unlisted codes outside raw mode, give one word with
// unsupported set and all channels zero. Each channel is multiplied by its
// 9-bit tint (256 = 1.0), truncated and clamped to 255.
// Pipeline: input register with nibble select and format decode, decoded
// pixel register, product register (four 8x9 multipliers), saturated output
// register. Sustained rate: one pixel per cycle while out_ready is high;
// single-pixel formats take a new word with every pixel and nibble formats
// with every second pixel, as the input register's nibble sequencing sets.
// Stalls on out_ready back up stage by stage; bubbles are squeezed out.
// Configuration writes are always ready and take effect at once; write them
// only while the block is idle.
module texel_format_to_rgba8 (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // source word channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [31:0]                   source_word,
  input  wire logic                          final_unit,
  // pixel word channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic [7:0]                         alpha,
  output logic                               run_end,
  output logic                               texture_end,
  output logic                               unsupported
);
  import tfr_pkg::*;

  // configuration registers
  logic [3:0]        texel_format;
  logic              load_raw;
  logic [TINT_W-1:0] tint_red;
  logic [TINT_W-1:0] tint_green;
  logic [TINT_W-1:0] tint_blue;
  logic [TINT_W-1:0] tint_alpha;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format <= FMT_RGBA32;
      load_raw     <= 1'b0;
      tint_red     <= TINT_ONE;
      tint_green   <= TINT_ONE;
      tint_blue    <= TINT_ONE;
      tint_alpha   <= TINT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FORMAT:     texel_format <= cfg_data[3:0];
        CFG_LOAD_RAW:   load_raw     <= cfg_data[0];
        CFG_TINT_RED:   tint_red     <= cfg_data;
        CFG_TINT_GREEN: tint_green   <= cfg_data;
        CFG_TINT_BLUE:  tint_blue    <= cfg_data;
        CFG_TINT_ALPHA: tint_alpha   <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // stage enables, from the output back
  logic adv1;
  logic adv2;
  logic adv3;

  // stage 0: held source word, sequenced one pixel at a time
  logic        s0_valid;
  logic [31:0] s0_word;
  logic        s0_fin;
  logic        s0_half;
  tfr_pixel_t  s0_pix;

  tfr_expand u_expand (
    .fmt  (texel_format),
    .raw  (load_raw),
    .word (s0_word),
    .half (s0_half),
    .pix  (s0_pix)
  );

  assign in_ready = !s0_valid || (adv1 && s0_pix.run_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s0_half  <= 1'b0;
    end else if (in_valid && in_ready) begin
      s0_valid <= 1'b1;
      s0_half  <= 1'b0;
    end else if (s0_valid && adv1) begin
      // last pixel leaves: empty; else step to the low nibble
      if (s0_pix.run_end) begin
        s0_valid <= 1'b0;
      end else begin
        s0_half <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_word <= source_word;
      s0_fin  <= final_unit;
    end
  end

  // stage 1: decoded pixel
  logic       s1_valid;
  tfr_pixel_t s1_pix;
  logic       s1_fin;

  // stage 2: tint products
  logic        s2_valid;
  logic [16:0] s2_prod_r;
  logic [16:0] s2_prod_g;
  logic [16:0] s2_prod_b;
  logic [16:0] s2_prod_a;
  logic        s2_run_end;
  logic        s2_fin;
  logic        s2_unsup;

  // stage 3: output register
  logic s3_valid;

  assign adv3 = !s3_valid || out_ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= s0_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s0_valid) begin
      s1_pix <= s0_pix;
      s1_fin <= s0_fin;
    end
  end

  // 8 x 9 products; unsupported pixels carry zero channels so they stay zero
  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_prod_r  <= 17'(s1_pix.red)   * 17'(tint_red);
      s2_prod_g  <= 17'(s1_pix.green) * 17'(tint_green);
      s2_prod_b  <= 17'(s1_pix.blue)  * 17'(tint_blue);
      s2_prod_a  <= 17'(s1_pix.alpha) * 17'(tint_alpha);
      s2_run_end <= s1_pix.run_end;
      s2_fin     <= s1_fin;
      s2_unsup   <= s1_pix.unsupported;
    end
  end

  // drop 8 fraction bits, clamp at 255
  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      red         <= s2_prod_r[16] ? 8'hFF : s2_prod_r[15:8];
      green       <= s2_prod_g[16] ? 8'hFF : s2_prod_g[15:8];
      blue        <= s2_prod_b[16] ? 8'hFF : s2_prod_b[15:8];
      alpha       <= s2_prod_a[16] ? 8'hFF : s2_prod_a[15:8];
      run_end     <= s2_run_end;
      texture_end <= s2_run_end && s2_fin;
      unsupported <= s2_unsup;
    end
  end

  assign out_valid = s3_valid;

endmodule

`default_nettype wire

// File: test/texel_format_to_rgba8_test.sv
// Self-checking testbench for the texel format expander with per-channel tint.
`timescale 1ns / 1ps

// Directed and random source words run through texel_format_to_rgba8 under many
// register settings. Each accepted source word is expanded here into its one or
// two expected pixel words; every pixel word the block emits is checked field by
// field against the oldest expectation. Registers change only while the block
// is drained. Phases rotate through four handshake patterns: no idling, source
// idle 75%, sink stalling 75%, and both at 22%.
module texel_format_to_rgba8_test;
  import tfr_pkg::*;

  // spare register indexes: writes there must not disturb anything
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam logic [8:0] TINT_MAX     = 9'd511;
  localparam int         RANDOM_PHASES = 40;
  localparam int         WORDS_PER_PHASE = 20;

  typedef struct packed {
    logic [31:0] data;
    logic        last;
  } source_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       run_end;
    logic       texture_end;
    logic       unsupported;
  } pixel_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [31:0]            source_word = '0;
  logic                   final_unit = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic [7:0]             alpha;
  logic                   run_end;
  logic                   texture_end;
  logic                   unsupported;

  texel_format_to_rgba8 uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .source_word (source_word),
    .final_unit  (final_unit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .run_end     (run_end),
    .texture_end (texture_end),
    .unsupported (unsupported)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #400000;
    $display("[texel_format_to_rgba8] ERROR");
    $finish;
  end

  // Shadow copy of the block's registers, updated on each accepted write.
  logic [3:0] cur_format   = FMT_RGBA32;
  logic       cur_raw      = 1'b0;
  logic [8:0] cur_tint_red = TINT_ONE;
  logic [8:0] cur_tint_grn = TINT_ONE;
  logic [8:0] cur_tint_blu = TINT_ONE;
  logic [8:0] cur_tint_alp = TINT_ONE;

  source_item_t source_pending[$];   // source words not yet driven
  pixel_word_t  pixel_expected[$];   // pixel words still owed by the block
  source_item_t drive_item;
  int unsigned  words_queued = 0;
  int unsigned  words_taken  = 0;
  int unsigned  mismatches   = 0;
  logic         word_taken   = 1'b0; // source word accepted at the last rising edge
  int unsigned  src_idle_pct   = 0;
  int unsigned  sink_stall_pct = 0;

  // (channel * tint) >> 8, clamped to 255
  function automatic logic [7:0] tinted(input logic [7:0] ch, input logic [8:0] tint);
    logic [16:0] prod;
    prod = {9'd0, ch} * {8'd0, tint};
    if (prod[16:8] > 9'd255) tinted = 8'hFF;
    else tinted = prod[15:8];
  endfunction

  function automatic void push_pixel(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] a,
                                     input logic last, input logic fin,
                                     input logic unsup);
    pixel_word_t p;
    p.red         = unsup ? 8'd0 : tinted(r, cur_tint_red);
    p.green       = unsup ? 8'd0 : tinted(g, cur_tint_grn);
    p.blue        = unsup ? 8'd0 : tinted(b, cur_tint_blu);
    p.alpha       = unsup ? 8'd0 : tinted(a, cur_tint_alp);
    p.run_end     = last;
    p.texture_end = last && fin;
    p.unsupported = unsup;
    pixel_expected = {pixel_expected, p};
  endfunction

  // Expected pixel words for one source word under the current registers.
  function automatic void expand_texel(input logic [31:0] w, input logic fin);
    logic [7:0] b1, b2, c, a;
    logic [3:0] hi, lo, mode;
    b1 = w[15:8];
    b2 = w[7:0];
    hi = b2[7:4];
    lo = b2[3:0];
    mode = cur_format;
    // palettes stay unsupported even in raw mode
    if (mode == FMT_PAL4 || mode == FMT_PAL8) begin
      push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, fin, 1'b1);
    end else begin
      if (cur_raw) mode = FMT_RGBA32;
      case (mode)
        FMT_RGBA32: push_pixel(w[31:24], w[23:16], w[15:8], w[7:0], 1'b1, fin, 1'b0);
        FMT_RGBA16: push_pixel(8'(b1[7:3] * 255 / 31),
                               8'({b1[2:0], b2[7:6]} * 255 / 31),
                               8'(b2[5:1] * 255 / 31),
                               b2[0] ? 8'hFF : 8'h00, 1'b1, fin, 1'b0);
        FMT_IA16: push_pixel(b1, b1, b1, b2, 1'b1, fin, 1'b0);
        FMT_IA8: begin
          c = 8'(hi * 255 / 15);
          a = 8'(lo * 255 / 15);
          push_pixel(c, c, c, a, 1'b1, fin, 1'b0);
        end
        FMT_IA4: begin
          // high nibble first, run_end only on the second
          c = 8'(hi[3:1] * 255 / 7);
          a = hi[0] ? 8'hFF : 8'h00;
          push_pixel(c, c, c, a, 1'b0, fin, 1'b0);
          c = 8'(lo[3:1] * 255 / 7);
          a = lo[0] ? 8'hFF : 8'h00;
          push_pixel(c, c, c, a, 1'b1, fin, 1'b0);
        end
        FMT_I8: push_pixel(b2, b2, b2, 8'hFF, 1'b1, fin, 1'b0);
        FMT_I4: begin
          c = 8'(hi * 255 / 15);
          push_pixel(c, c, c, 8'hFF, 1'b0, fin, 1'b0);
          c = 8'(lo * 255 / 15);
          push_pixel(c, c, c, 8'hFF, 1'b1, fin, 1'b0);
        end
        // unlisted codes outside raw mode
        default: push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, fin, 1'b1);
      endcase
    end
  endfunction

  // Source driver: new word or idle at the falling edge, hold until taken.
  // The sink's ready is also chosen here.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      // stalled: keep valid and payload
    end else if (source_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
      drive_item = source_pending.pop_front();
      in_valid    <= 1'b1;
      source_word <= drive_item.data;
      final_unit  <= drive_item.last;
    end else begin
      in_valid <= 1'b0;
    end
    out_ready <= !rst && ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: predict on each accepted source word, check each pixel word.
  always @(posedge clk) begin
    pixel_word_t want, got;
    word_taken <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      expand_texel(source_word, final_unit);
      words_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      got = {red, green, blue, alpha, run_end, texture_end, unsupported};
      if (pixel_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel word: r=%0d g=%0d b=%0d a=%0d run=%0b tex=%0b uns=%0b",
                   got.red, got.green, got.blue, got.alpha,
                   got.run_end, got.texture_end, got.unsupported);
      end else begin
        want = pixel_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected r=%0d g=%0d b=%0d a=%0d run=%0b tex=%0b uns=%0b",
                     want.red, want.green, want.blue, want.alpha,
                     want.run_end, want.texture_end, want.unsupported);
            $display("          got      r=%0d g=%0d b=%0d a=%0d run=%0b tex=%0b uns=%0b",
                     got.red, got.green, got.blue, got.alpha,
                     got.run_end, got.texture_end, got.unsupported);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FORMAT:     cur_format   = data[3:0];
      CFG_LOAD_RAW:   cur_raw      = data[0];
      CFG_TINT_RED:   cur_tint_red = data;
      CFG_TINT_GREEN: cur_tint_grn = data;
      CFG_TINT_BLUE:  cur_tint_blu = data;
      CFG_TINT_ALPHA: cur_tint_alp = data;
      default: ;
    endcase
  endtask

  // Only called with the block drained.
  task automatic configure(input logic [3:0] fmt, input logic raw,
                           input logic [8:0] tr, input logic [8:0] tg,
                           input logic [8:0] tb, input logic [8:0] ta,
                           input logic spare);
    write_reg(CFG_FORMAT, {5'd0, fmt});
    write_reg(CFG_LOAD_RAW, {8'd0, raw});
    write_reg(CFG_TINT_RED, tr);
    write_reg(CFG_TINT_GREEN, tg);
    write_reg(CFG_TINT_BLUE, tb);
    write_reg(CFG_TINT_ALPHA, ta);
    if (spare)
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 9'($urandom()));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_word(input logic [31:0] data, input logic last);
    source_item_t it;
    it.data = data;
    it.last = last;
    source_pending = {source_pending, it};
    words_queued++;
  endtask

  // every queued word accepted and every pixel word seen
  task automatic drain();
    while (words_taken != words_queued || pixel_expected.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [8:0] pick_tint();
    case ($urandom_range(5))
      0: pick_tint = 9'd0;
      1: pick_tint = TINT_ONE;
      2: pick_tint = TINT_MAX;
      3: pick_tint = 9'd255;
      default: pick_tint = 9'($urandom_range(511));
    endcase
  endfunction

  // bytes lean toward 00 and FF so nibble and 5-bit edges come up often
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(3))
        0: w[8*k +: 8] = 8'h00;
        1: w[8*k +: 8] = 8'hFF;
        default: w[8*k +: 8] = 8'($urandom());
      endcase
    end
    rand_word = w;
  endfunction

  task automatic directed_pair();
    queue_word(32'h0000_0000, 1'b0);
    queue_word(32'hFFFF_FFFF, 1'b1);
    drain();
  endtask

  initial begin
    logic [3:0] fmt;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every format at unit tint with all-zero and all-one words,
    // then an unlisted code, a palette in raw mode, and raw mode with
    // saturating, zero and odd tints.
    for (int f = 0; f <= 8; f++) begin
      configure(4'(f), 1'b0, TINT_ONE, TINT_ONE, TINT_ONE, TINT_ONE, 1'b0);
      directed_pair();
    end
    configure(4'd12, 1'b0, TINT_ONE, TINT_ONE, TINT_ONE, TINT_ONE, 1'b0);
    directed_pair();
    configure(FMT_PAL4, 1'b1, TINT_ONE, TINT_ONE, TINT_ONE, TINT_ONE, 1'b0);
    directed_pair();
    configure(FMT_RGBA16, 1'b1, TINT_MAX, 9'd0, 9'd300, 9'd1, 1'b1);
    directed_pair();

    // Random phases, each ending in a final word, with more final words at random.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      fmt = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
      configure(fmt, $urandom_range(3) == 0, pick_tint(), pick_tint(), pick_tint(),
                pick_tint(), $urandom_range(7) == 0);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++)
        queue_word(rand_word(), i == WORDS_PER_PHASE - 1 || $urandom_range(9) == 0);
      drain();
    end

    // let any stray pixel word surface past the pipeline depth
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[texel_format_to_rgba8] OK");
    end else begin
      $display("[texel_format_to_rgba8] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/tfr_pkg.sv
sv/tfr_expand.sv
sv/texel_format_to_rgba8.sv
test/texel_format_to_rgba8_test.sv
